>>> hdl/gcone_pkg.sv
// Package for the game graph cone engine.
// Holds the field widths, command and edge class codes, and the sequencer state type.
// No dependencies.
package gcone_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam int NODE_TOTAL_W = 11;
    localparam int EDGE_TOTAL_W = 13;
    localparam int PASS_W       = 11;
    localparam int FIELD_NODE_W = 10;
    localparam int FIELD_SLOT_W = 12;
    localparam int FIELD_CLS_W  = 2;
    localparam int MODE_W       = 3;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 16;
    localparam int EDGE_ENTRY_W = 2 * FIELD_NODE_W + FIELD_CLS_W;

    localparam logic [MODE_W-1:0] MODE_LOAD_NODE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_EDGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FRAGILE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NONFAIL   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_NODE = 3'd5;

    localparam logic [FIELD_CLS_W-1:0] CLS_CTRL   = 2'd0;
    localparam logic [FIELD_CLS_W-1:0] CLS_UNCTRL = 2'd1;
    localparam logic [FIELD_CLS_W-1:0] CLS_FAIL   = 2'd2;

    localparam logic [0:0] REG_NODE_TOTAL = 1'b0;
    localparam logic [0:0] REG_EDGE_TOTAL = 1'b1;

    typedef enum logic [5:0] {
        S_CLR,
        S_IDLE,
        S_RD_W,
        S_NF_I,
        S_NF_RD,
        S_NF_WR,
        S_FR_IR,
        S_FR_IW,
        S_FR_RD,
        S_FR_S,
        S_FR_D,
        S_FR_W,
        S_CN_CLR,
        S_CN_CR,
        S_CN_CE,
        S_CN_CW,
        S_PF_RD,
        S_PF_WR,
        S_FL_RD,
        S_FL_EV,
        S_FL_WR,
        S_CI_RD,
        S_CI_WR,
        S_SW_ST,
        S_SW_RD,
        S_SW_EV,
        S_SW_B0,
        S_SW_B1,
        S_SW_K,
        S_SW_KD,
        S_SW_KR
    } t_state;

endpackage

>>> hdl/gcone_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gcone_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/game_graph_cone_engine_unit.sv
// Top level of the game graph cone engine: command stream in, one response per command out.
// Depends on gcone_pkg and gcone_ram.
//
//  channel   | direction | accepted when            | contents
//  s_axis    | in        | tvalid & tready          | command (tuser mode, tdata arguments)
//  m_axis    | out       | tvalid & tready          | member, pass_count, status
//  apb       | in        | psel & penable & pwrite  | node_total at 0, edge_total at 4
//
// Load and unknown commands are answered from the idle state; read node waits for one RAM read.
// Nonfailure and fragile run times grow with MAX_NODES and the edge count; cone's also with the
// node count and its sweeps, each of which visits every node and scans the edges of each L-node
// not yet in the set; the single read port of each RAM sets these.
// After reset a clearing pass over all MAX_NODES node entries runs before the first command is taken.
// One command is in work at a time; the next is taken once its response has been delivered.
module game_graph_cone_engine_unit #(
    parameter int MAX_NODES = gcone_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gcone_pkg::DEF_MAX_EDGES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_index[9:0], in_l[10], in_g[11], edge_slot[23:12], edge_from[33:24],
    // edge_to[43:34], edge_class[45:44], zero fill
    input  logic [gcone_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [gcone_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // member[0], pass_count[11:1], status[12], zero fill
    output logic [gcone_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import gcone_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    // Configuration.
    logic [NODE_TOTAL_W-1:0] r_node_total;
    logic [EDGE_TOTAL_W-1:0] r_edge_total;
    logic                    w_cfg_wr;
    logic [CW-1:0]           w_n;
    logic [ECW-1:0]          w_e;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_total <= NODE_TOTAL_W'(1);
            r_edge_total <= '0;
        end else if (w_cfg_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_NODE_TOTAL) begin
                r_node_total <= pwdata[NODE_TOTAL_W-1:0];
            end else begin
                r_edge_total <= pwdata[EDGE_TOTAL_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_NODE_TOTAL) begin
            prdata = 32'(r_node_total);
        end else begin
            prdata = 32'(r_edge_total);
        end
    end

    assign w_n = (32'(r_node_total) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(r_node_total);
    assign w_e = (32'(r_edge_total) > 32'(MAX_EDGES)) ? ECW'(MAX_EDGES) : ECW'(r_edge_total);

    // Command fields.
    logic [MODE_W-1:0]       w_mode;
    logic [FIELD_NODE_W-1:0] w_node;
    logic                    w_in_l;
    logic                    w_in_g;
    logic [FIELD_SLOT_W-1:0] w_slot;
    logic [FIELD_NODE_W-1:0] w_from;
    logic [FIELD_NODE_W-1:0] w_to;
    logic [FIELD_CLS_W-1:0]  w_cls;
    logic                    w_acc;
    logic                    w_node_ok;
    logic                    w_slot_ok;

    assign w_mode    = s_axis_tuser;
    assign w_node    = s_axis_tdata[9:0];
    assign w_in_l    = s_axis_tdata[10];
    assign w_in_g    = s_axis_tdata[11];
    assign w_slot    = s_axis_tdata[23:12];
    assign w_from    = s_axis_tdata[33:24];
    assign w_to      = s_axis_tdata[43:34];
    assign w_cls     = s_axis_tdata[45:44];
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_node_ok = 32'(w_node) < 32'(w_n);
    assign w_slot_ok = 32'(w_slot) < 32'(w_e);

    // Memories.
    logic                    lg_we;
    logic [NW-1:0]           lg_waddr, lg_raddr;
    logic [1:0]              lg_wdata, lg_rdata;
    logic                    rs_we;
    logic [NW-1:0]           rs_waddr, rs_raddr;
    logic                    rs_wdata, rs_rdata;
    logic                    ed_we;
    logic [EW-1:0]           ed_waddr, ed_raddr;
    logic [EDGE_ENTRY_W-1:0] ed_wdata, ed_rdata;
    logic                    gs_we;
    logic [CW-1:0]           gs_waddr, gs_raddr;
    logic [ECW-1:0]          gs_wdata, gs_rdata;
    logic                    fl_we;
    logic [NW-1:0]           fl_waddr, fl_raddr;
    logic [ECW-1:0]          fl_wdata, fl_rdata;
    logic                    gd_we;
    logic [EW-1:0]           gd_waddr, gd_raddr;
    logic [NW-1:0]           gd_wdata, gd_rdata;

    gcone_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_lg_ram (
        .i_clk, .i_we(lg_we), .i_waddr(lg_waddr), .i_wdata(lg_wdata),
        .i_raddr(lg_raddr), .o_rdata(lg_rdata)
    );
    gcone_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_rs_ram (
        .i_clk, .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );
    gcone_ram #(.WIDTH(EDGE_ENTRY_W), .DEPTH(MAX_EDGES)) u_ed_ram (
        .i_clk, .i_we(ed_we), .i_waddr(ed_waddr), .i_wdata(ed_wdata),
        .i_raddr(ed_raddr), .o_rdata(ed_rdata)
    );
    gcone_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_gs_ram (
        .i_clk, .i_we(gs_we), .i_waddr(gs_waddr), .i_wdata(gs_wdata),
        .i_raddr(gs_raddr), .o_rdata(gs_rdata)
    );
    gcone_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_fl_ram (
        .i_clk, .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rdata)
    );
    gcone_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_gd_ram (
        .i_clk, .i_we(gd_we), .i_waddr(gd_waddr), .i_wdata(gd_wdata),
        .i_raddr(gd_raddr), .o_rdata(gd_rdata)
    );

    // Fields of the edge entry last read.
    logic [FIELD_NODE_W-1:0] w_es, w_ed;
    logic [FIELD_CLS_W-1:0]  w_ec;
    logic                    w_eok;

    assign w_es  = ed_rdata[FIELD_NODE_W-1:0];
    assign w_ed  = ed_rdata[2*FIELD_NODE_W-1:FIELD_NODE_W];
    assign w_ec  = ed_rdata[EDGE_ENTRY_W-1:2*FIELD_NODE_W];
    assign w_eok = (32'(w_es) < 32'(w_n)) && (32'(w_ed) < 32'(w_n));

    // Sequencer.
    t_state         r_state, n_state;
    logic [CW-1:0]  r_i, n_i;
    logic [ECW-1:0] r_k, n_k;
    logic [ECW-1:0] r_end, n_end;
    logic [ECW-1:0] r_sum, n_sum;
    logic           r_gsrc, n_gsrc;
    logic           r_changed, n_changed;
    logic           r_ok, n_ok;
    logic [PASS_W-1:0] r_passes, n_passes;
    logic [PASS_W-1:0] r_last, n_last;
    logic           r_ovalid, n_ovalid;
    logic           r_member, n_member;
    logic           r_status, n_status;
    logic           w_i_last;

    assign w_i_last      = 32'(r_i) == 32'(MAX_NODES - 1);
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_status, r_last, r_member};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_i      <= '0;
            r_ovalid <= 1'b0;
            r_last   <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_end     <= n_end;
        r_sum     <= n_sum;
        r_gsrc    <= n_gsrc;
        r_changed <= n_changed;
        r_ok      <= n_ok;
        r_passes  <= n_passes;
        r_member  <= n_member;
        r_status  <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_k       = r_k;
        n_end     = r_end;
        n_sum     = r_sum;
        n_gsrc    = r_gsrc;
        n_changed = r_changed;
        n_ok      = r_ok;
        n_passes  = r_passes;
        n_last    = r_last;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_member  = r_member;
        n_status  = r_status;

        lg_we = 1'b0; lg_waddr = NW'(r_i); lg_wdata = '0; lg_raddr = NW'(r_i);
        rs_we = 1'b0; rs_waddr = NW'(r_i); rs_wdata = 1'b0; rs_raddr = NW'(r_i);
        ed_we = 1'b0; ed_waddr = EW'(w_slot); ed_wdata = {w_cls, w_to, w_from};
        ed_raddr = EW'(r_k);
        gs_we = 1'b0; gs_waddr = r_i; gs_wdata = '0; gs_raddr = r_i;
        fl_we = 1'b0; fl_waddr = NW'(r_i); fl_wdata = r_sum; fl_raddr = NW'(w_es);
        gd_we = 1'b0; gd_waddr = EW'(fl_rdata); gd_wdata = NW'(w_ed); gd_raddr = EW'(r_k);

        case (r_state)
            S_CLR: begin
                lg_we = 1'b1;
                rs_we = 1'b1;
                n_i   = r_i + 1'b1;
                if (w_i_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_i = '0;
                n_k = '0;
                if (w_acc) begin
                    n_member = 1'b0;
                    n_status = 1'b0;
                    case (w_mode)
                        MODE_LOAD_NODE: begin
                            lg_we    = w_node_ok;
                            lg_waddr = NW'(w_node);
                            lg_wdata = {w_in_l, w_in_g};
                            n_status = !w_node_ok;
                            n_ovalid = 1'b1;
                        end
                        MODE_LOAD_EDGE: begin
                            ed_we    = w_slot_ok;
                            n_status = !w_slot_ok;
                            n_ovalid = 1'b1;
                        end
                        MODE_CONE:    n_state = S_CN_CLR;
                        MODE_FRAGILE: n_state = S_FR_IR;
                        MODE_NONFAIL: n_state = S_NF_I;
                        MODE_READ_NODE: begin
                            rs_raddr = NW'(w_node);
                            n_ok     = w_node_ok;
                            n_state  = S_RD_W;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            S_RD_W: begin
                n_member = r_ok && rs_rdata;
                n_status = !r_ok;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end

            // Nonfailure: mark every node in use, then clear failure targets.
            S_NF_I: begin
                rs_we    = 1'b1;
                rs_wdata = r_i < w_n;
                n_i      = r_i + 1'b1;
                if (w_i_last) begin
                    n_state = S_NF_RD;
                end
            end
            S_NF_RD: begin
                if (r_k < w_e) begin
                    n_state = S_NF_WR;
                end else begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_NF_WR: begin
                rs_we    = w_eok && (w_ec == CLS_FAIL);
                rs_waddr = NW'(w_ed);
                rs_wdata = 1'b0;
                n_k      = r_k + 1'b1;
                n_state  = S_NF_RD;
            end

            // Fragile: complement of G, then G-nodes with a risky edge out of G.
            S_FR_IR: n_state = S_FR_IW;
            S_FR_IW: begin
                rs_we    = 1'b1;
                rs_wdata = (r_i < w_n) && !lg_rdata[0];
                n_i      = r_i + 1'b1;
                n_state  = w_i_last ? S_FR_RD : S_FR_IR;
            end
            S_FR_RD: begin
                if (r_k < w_e) begin
                    n_state = S_FR_S;
                end else begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FR_S: begin
                lg_raddr = NW'(w_es);
                n_state  = S_FR_D;
            end
            S_FR_D: begin
                n_gsrc   = lg_rdata[0];
                lg_raddr = NW'(w_ed);
                n_state  = S_FR_W;
            end
            S_FR_W: begin
                rs_we    = w_eok && (w_ec == CLS_UNCTRL || w_ec == CLS_FAIL) &&
                           r_gsrc && !lg_rdata[0];
                rs_waddr = NW'(w_es);
                rs_wdata = 1'b1;
                n_k      = r_k + 1'b1;
                n_state  = S_FR_RD;
            end

            // Cone, step one: count controllable edges per source at slot src+1.
            S_CN_CLR: begin
                gs_we = 1'b1;
                n_i   = r_i + 1'b1;
                if (r_i == w_n) begin
                    n_state = S_CN_CR;
                end
            end
            S_CN_CR: begin
                if (r_k < w_e) begin
                    n_state = S_CN_CE;
                end else begin
                    n_i     = '0;
                    n_sum   = '0;
                    n_state = S_PF_RD;
                end
            end
            S_CN_CE: begin
                gs_raddr = CW'(w_es) + 1'b1;
                if (w_eok && w_ec == CLS_CTRL) begin
                    n_state = S_CN_CW;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_CN_CR;
                end
            end
            S_CN_CW: begin
                gs_we    = 1'b1;
                gs_waddr = CW'(w_es) + 1'b1;
                gs_wdata = gs_rdata + 1'b1;
                n_k      = r_k + 1'b1;
                n_state  = S_CN_CR;
            end

            // Step two: running sum gives each group's start and fill pointer.
            S_PF_RD: begin
                gs_raddr = r_i + 1'b1;
                if (r_i < w_n) begin
                    n_state = S_PF_WR;
                end else begin
                    n_k     = '0;
                    n_state = S_FL_RD;
                end
            end
            S_PF_WR: begin
                gs_we    = 1'b1;
                gs_waddr = r_i + 1'b1;
                gs_wdata = r_sum + gs_rdata;
                fl_we    = 1'b1;
                n_sum    = r_sum + gs_rdata;
                n_i      = r_i + 1'b1;
                n_state  = S_PF_RD;
            end

            // Step three: place each controllable edge's target in its group.
            S_FL_RD: begin
                if (r_k < w_e) begin
                    n_state = S_FL_EV;
                end else begin
                    n_i     = '0;
                    n_state = S_CI_RD;
                end
            end
            S_FL_EV: begin
                if (w_eok && w_ec == CLS_CTRL) begin
                    n_state = S_FL_WR;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_FL_RD;
                end
            end
            S_FL_WR: begin
                gd_we    = 1'b1;
                fl_we    = 1'b1;
                fl_waddr = NW'(w_es);
                fl_wdata = fl_rdata + 1'b1;
                n_k      = r_k + 1'b1;
                n_state  = S_FL_RD;
            end

            // Step four: result starts as G.
            S_CI_RD: n_state = S_CI_WR;
            S_CI_WR: begin
                rs_we    = 1'b1;
                rs_wdata = (r_i < w_n) && lg_rdata[0];
                n_i      = r_i + 1'b1;
                if (w_i_last) begin
                    n_passes = '0;
                    n_state  = S_SW_ST;
                end else begin
                    n_state = S_CI_RD;
                end
            end

            // Sweeps in ascending node order until one changes nothing.
            S_SW_ST: begin
                if (r_passes != '1) begin
                    n_passes = r_passes + 1'b1;
                end
                n_changed = 1'b0;
                n_i       = '0;
                n_state   = S_SW_RD;
            end
            S_SW_RD: begin
                if (r_i < w_n) begin
                    n_state = S_SW_EV;
                end else if (r_changed) begin
                    n_state = S_SW_ST;
                end else begin
                    n_last   = r_passes;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SW_EV: begin
                if (lg_rdata[1] && !rs_rdata) begin
                    n_state = S_SW_B0;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SW_RD;
                end
            end
            S_SW_B0: begin
                n_k      = gs_rdata;
                gs_raddr = r_i + 1'b1;
                n_state  = S_SW_B1;
            end
            S_SW_B1: begin
                n_end   = gs_rdata;
                n_state = S_SW_K;
            end
            S_SW_K: begin
                if (r_k < r_end) begin
                    n_state = S_SW_KD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SW_RD;
                end
            end
            S_SW_KD: begin
                rs_raddr = gd_rdata;
                n_state  = S_SW_KR;
            end
            S_SW_KR: begin
                if (rs_rdata) begin
                    rs_we     = 1'b1;
                    rs_wdata  = 1'b1;
                    n_changed = 1'b1;
                    n_i       = r_i + 1'b1;
                    n_state   = S_SW_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SW_K;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
